// File: design/ohs_pkg.sv
// Shared types, codes and defaults for the open-addressing hash set.
package ohs_pkg;

    localparam int DEF_SLOTS    = 1024;
    localparam int DEF_KEY_BITS = 32;
    localparam int KEY_PORT_W   = 32;
    localparam int HASH_W       = 32;
    localparam int FUNC_W       = 3;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 11;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD      = 3'd0,
        FN_CONTAINS = 3'd1,
        FN_REMOVE   = 3'd2,
        FN_DISCARD  = 3'd3,
        FN_CLEAR    = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK   = 2'd0,
        STS_TYPE = 2'd1,
        STS_KEY  = 2'd2,
        STS_FULL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_REUSE,
        ACT_DELETE
    } act_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PROBE,
        ST_CLEAR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic live;
        logic tomb;
    } slot_meta_t;

    typedef struct packed {
        logic meta_we;
        logic data_we;
    } tbl_wr_t;

endpackage

// File: design/ohs_table.sv
// Slot storage: per-slot state memory and key/hash memory, one read and one write port each.
module ohs_table #(
    parameter int SLOTS = ohs_pkg::DEF_SLOTS,
    parameter int KEY_W = ohs_pkg::KEY_PORT_W
) (
    input  logic                          clk,
    input  logic [$clog2(SLOTS)-1:0]      rd_addr,
    output ohs_pkg::slot_meta_t           rd_meta,
    output logic [KEY_W-1:0]              rd_key,
    output logic [ohs_pkg::HASH_W-1:0]    rd_hash,
    input  ohs_pkg::tbl_wr_t              wr,
    input  logic [$clog2(SLOTS)-1:0]      wr_addr,
    input  ohs_pkg::slot_meta_t           wr_meta,
    input  logic [KEY_W-1:0]              wr_key,
    input  logic [ohs_pkg::HASH_W-1:0]    wr_hash
);

    localparam int DATA_W = KEY_W + ohs_pkg::HASH_W;

    ohs_pkg::slot_meta_t meta_mem [SLOTS];
    logic [DATA_W-1:0]   data_mem [SLOTS];

    ohs_pkg::slot_meta_t rd_meta_reg;
    logic [DATA_W-1:0]   rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.meta_we)
        begin
            meta_mem[wr_addr] <= wr_meta;
        end
        rd_meta_reg <= meta_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.data_we)
        begin
            data_mem[wr_addr] <= {wr_key, wr_hash};
        end
        rd_data_reg <= data_mem[rd_addr];
    end

    assign rd_meta = rd_meta_reg;
    assign rd_key  = rd_data_reg[DATA_W-1:ohs_pkg::HASH_W];
    assign rd_hash = rd_data_reg[ohs_pkg::HASH_W-1:0];

endmodule

// File: design/open_addressing_hash_set.sv
// Top level of the open-addressing hash set with linear probing and tombstones.
//
//  channel | dir | handshake              | fields
//  --------+-----+------------------------+-------------------------------------
//  request | in  | req_valid / req_stall  | func, key, key_hash, hashable
//  result  | out | rsp_valid / rsp_stall  | status, present, member_count
//
//  Add, contains, remove, discard: slots are probed one per cycle through the state memory
//  read port, up to SLOTS slots per request.
//  Requests that skip the probe (errors, empty set, unused codes) go straight to finish.
//  Clear: one slot state entry written per cycle, over all SLOTS entries.
//  After reset: every slot state entry is cleared before the first request is taken.
//  A waiting result is held in the output register; the next request is taken meanwhile,
//  and a request finishes only once the output register is free.
module open_addressing_hash_set #(
    parameter int SLOTS    = ohs_pkg::DEF_SLOTS,
    parameter int KEY_BITS = ohs_pkg::DEF_KEY_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [ohs_pkg::FUNC_W-1:0]      func,
    input  logic [ohs_pkg::KEY_PORT_W-1:0]  key,
    input  logic [ohs_pkg::HASH_W-1:0]      key_hash,
    input  logic                            hashable,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [ohs_pkg::STATUS_W-1:0]    status,
    output logic                            present,
    output logic [ohs_pkg::COUNT_W-1:0]     member_count
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int KEY_W  = (KEY_BITS < ohs_pkg::KEY_PORT_W) ? KEY_BITS : ohs_pkg::KEY_PORT_W;
    localparam int LOAD_W = CNT_W + 3;
    localparam int CW     = ohs_pkg::COUNT_W;
    localparam int HW     = ohs_pkg::HASH_W;
    localparam int FW     = ohs_pkg::FUNC_W;
    localparam logic [LOAD_W-1:0] LOAD_LIMIT = LOAD_W'(SLOTS * 3);

    ohs_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             have_tomb_reg, have_tomb_next;
    logic [IDX_W-1:0] tomb_idx_reg, tomb_idx_next;
    logic [CNT_W-1:0] live_reg, live_next;
    logic [CNT_W-1:0] tomb_reg, tomb_next;
    ohs_pkg::act_t    act_reg, act_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    ohs_pkg::status_t status_reg, status_next;
    logic             present_reg, present_next;
    logic [FW-1:0]    func_reg, func_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [HW-1:0]    hash_reg, hash_next;

    logic             rsp_valid_reg, rsp_valid_next;
    ohs_pkg::status_t rsp_status_reg, rsp_status_next;
    logic             rsp_present_reg, rsp_present_next;
    logic [CW-1:0]    rsp_count_reg, rsp_count_next;

    logic [IDX_W-1:0]    rd_addr;
    ohs_pkg::slot_meta_t rd_meta;
    logic [KEY_W-1:0]    rd_key;
    logic [HW-1:0]       rd_hash;
    ohs_pkg::tbl_wr_t    tbl_wr;
    logic [IDX_W-1:0]    wr_addr;
    ohs_pkg::slot_meta_t wr_meta;

    logic             is_clear;
    logic             is_keyop;
    logic             over_load;
    logic             probe_go;
    logic             idx_last;
    logic             out_free;
    logic             hit_now;
    logic             tomb_now;
    logic             empty_now;
    logic             probe_end;
    logic             have_tomb_any;
    logic             ins_ok;
    logic [IDX_W-1:0] ins_slot;
    logic [LOAD_W-1:0] load_sum;

    ohs_table #(
        .SLOTS (SLOTS),
        .KEY_W (KEY_W)
    ) u_table (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_meta (rd_meta),
        .rd_key  (rd_key),
        .rd_hash (rd_hash),
        .wr      (tbl_wr),
        .wr_addr (wr_addr),
        .wr_meta (wr_meta),
        .wr_key  (key_reg),
        .wr_hash (hash_reg)
    );

    assign is_clear  = (func == ohs_pkg::FN_CLEAR);
    assign is_keyop  = (func == ohs_pkg::FN_ADD) || (func == ohs_pkg::FN_CONTAINS) ||
                       (func == ohs_pkg::FN_REMOVE) || (func == ohs_pkg::FN_DISCARD);
    assign load_sum  = LOAD_W'(live_reg) + LOAD_W'(tomb_reg) + LOAD_W'(1);
    assign over_load = (load_sum << 2) > LOAD_LIMIT;
    assign probe_go  = is_keyop && hashable &&
                       ((func == ohs_pkg::FN_ADD) ? !over_load : (live_reg != '0));
    assign idx_last  = &idx_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign hit_now       = rd_meta.live && (rd_hash == hash_reg) && (rd_key == key_reg);
    assign tomb_now      = !rd_meta.live && rd_meta.tomb;
    assign empty_now     = !rd_meta.live && !rd_meta.tomb;
    assign probe_end     = hit_now || empty_now || (&cnt_reg);
    assign have_tomb_any = have_tomb_reg || tomb_now;
    assign ins_ok        = empty_now || have_tomb_any;
    assign ins_slot      = have_tomb_reg ? tomb_idx_reg : idx_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ohs_pkg::ST_INIT:
            begin
                if (idx_last)
                begin
                    state_next = ohs_pkg::ST_IDLE;
                end
            end
            ohs_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (is_clear)
                    begin
                        state_next = ohs_pkg::ST_CLEAR;
                    end
                    else if (probe_go)
                    begin
                        state_next = ohs_pkg::ST_PROBE;
                    end
                    else
                    begin
                        state_next = ohs_pkg::ST_FINISH;
                    end
                end
            end
            ohs_pkg::ST_PROBE:
            begin
                if (probe_end)
                begin
                    state_next = ohs_pkg::ST_FINISH;
                end
            end
            ohs_pkg::ST_CLEAR:
            begin
                if (idx_last)
                begin
                    state_next = ohs_pkg::ST_FINISH;
                end
            end
            ohs_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ohs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ohs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        have_tomb_next   = have_tomb_reg;
        tomb_idx_next    = tomb_idx_reg;
        live_next        = live_reg;
        tomb_next        = tomb_reg;
        act_next         = act_reg;
        slot_next        = slot_reg;
        status_next      = status_reg;
        present_next     = present_reg;
        func_next        = func_reg;
        key_next         = key_reg;
        hash_next        = hash_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        rsp_status_next  = rsp_status_reg;
        rsp_present_next = rsp_present_reg;
        rsp_count_next   = rsp_count_reg;
        rd_addr          = IDX_W'(idx_reg + 1'b1);
        tbl_wr           = '0;
        wr_addr          = slot_reg;
        wr_meta          = '{live: 1'b1, tomb: 1'b0};

        case (state_reg)
            ohs_pkg::ST_INIT, ohs_pkg::ST_CLEAR:
            begin
                tbl_wr.meta_we = 1'b1;
                wr_addr        = idx_reg;
                wr_meta        = '0;
                idx_next       = IDX_W'(idx_reg + 1'b1);
            end
            ohs_pkg::ST_IDLE:
            begin
                rd_addr = key_hash[IDX_W-1:0];
                if (req_valid)
                begin
                    act_next       = ohs_pkg::ACT_NONE;
                    status_next    = ohs_pkg::STS_OK;
                    present_next   = 1'b0;
                    idx_next       = key_hash[IDX_W-1:0];
                    cnt_next       = '0;
                    have_tomb_next = 1'b0;
                    func_next      = func;
                    key_next       = key[KEY_W-1:0];
                    hash_next      = key_hash;
                    if (is_clear)
                    begin
                        idx_next  = '0;
                        live_next = '0;
                        tomb_next = '0;
                    end
                    else if (is_keyop && !hashable)
                    begin
                        status_next = ohs_pkg::STS_TYPE;
                    end
                    else if ((func == ohs_pkg::FN_ADD) && over_load)
                    begin
                        status_next = ohs_pkg::STS_FULL;
                    end
                    else if (is_keyop && !probe_go && (func == ohs_pkg::FN_REMOVE))
                    begin
                        status_next = ohs_pkg::STS_KEY;
                    end
                end
            end
            ohs_pkg::ST_PROBE:
            begin
                if (probe_end)
                begin
                    case (func_reg)
                        ohs_pkg::FN_ADD:
                        begin
                            if (!hit_now)
                            begin
                                if (ins_ok)
                                begin
                                    act_next  = have_tomb_any ? ohs_pkg::ACT_REUSE
                                                              : ohs_pkg::ACT_INSERT;
                                    slot_next = ins_slot;
                                end
                                else
                                begin
                                    status_next = ohs_pkg::STS_FULL;
                                end
                            end
                        end
                        ohs_pkg::FN_CONTAINS:
                        begin
                            present_next = hit_now;
                        end
                        ohs_pkg::FN_REMOVE, ohs_pkg::FN_DISCARD:
                        begin
                            if (hit_now)
                            begin
                                act_next  = ohs_pkg::ACT_DELETE;
                                slot_next = idx_reg;
                            end
                            else if (func_reg == ohs_pkg::FN_REMOVE)
                            begin
                                status_next = ohs_pkg::STS_KEY;
                            end
                        end
                        default:
                        begin
                            act_next = ohs_pkg::ACT_NONE;
                        end
                    endcase
                end
                else
                begin
                    idx_next = IDX_W'(idx_reg + 1'b1);
                    cnt_next = IDX_W'(cnt_reg + 1'b1);
                    if (tomb_now && !have_tomb_reg)
                    begin
                        have_tomb_next = 1'b1;
                        tomb_idx_next  = idx_reg;
                    end
                end
            end
            ohs_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    case (act_reg)
                        ohs_pkg::ACT_INSERT:
                        begin
                            tbl_wr.meta_we = 1'b1;
                            tbl_wr.data_we = 1'b1;
                            live_next      = CNT_W'(live_reg + 1'b1);
                        end
                        ohs_pkg::ACT_REUSE:
                        begin
                            tbl_wr.meta_we = 1'b1;
                            tbl_wr.data_we = 1'b1;
                            live_next      = CNT_W'(live_reg + 1'b1);
                            tomb_next      = CNT_W'(tomb_reg - 1'b1);
                        end
                        ohs_pkg::ACT_DELETE:
                        begin
                            tbl_wr.meta_we = 1'b1;
                            wr_meta        = '{live: 1'b0, tomb: 1'b1};
                            live_next      = CNT_W'(live_reg - 1'b1);
                            tomb_next      = CNT_W'(tomb_reg + 1'b1);
                        end
                        default:
                        begin
                            tbl_wr = '0;
                        end
                    endcase
                    rsp_valid_next   = 1'b1;
                    rsp_status_next  = status_reg;
                    rsp_present_next = present_reg;
                    rsp_count_next   = CW'(live_next);
                end
            end
            default:
            begin
                tbl_wr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ohs_pkg::ST_INIT;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            have_tomb_reg <= 1'b0;
            live_reg      <= '0;
            tomb_reg      <= '0;
            act_reg       <= ohs_pkg::ACT_NONE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            have_tomb_reg <= have_tomb_next;
            live_reg      <= live_next;
            tomb_reg      <= tomb_next;
            act_reg       <= act_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tomb_idx_reg    <= tomb_idx_next;
        slot_reg        <= slot_next;
        status_reg      <= status_next;
        present_reg     <= present_next;
        func_reg        <= func_next;
        key_reg         <= key_next;
        hash_reg        <= hash_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_present_reg <= rsp_present_next;
        rsp_count_reg   <= rsp_count_next;
    end

    assign req_stall    = (state_reg != ohs_pkg::ST_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign status       = rsp_status_reg;
    assign present      = rsp_present_reg;
    assign member_count = rsp_count_reg;

endmodule

// File: design/ohs_checker.sv
// Port-level checker for the hash set and its bind to the top level.
module ohs_checker #(
    parameter int SLOTS = ohs_pkg::DEF_SLOTS
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_stall,
    input logic                            rsp_valid,
    input logic                            rsp_stall,
    input logic [ohs_pkg::STATUS_W-1:0]    status,
    input logic                            present,
    input logic [ohs_pkg::COUNT_W-1:0]     member_count
);

    logic [1:0] pend_reg, pend_next;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && !req_stall;
    assign rsp_acc = rsp_valid && !rsp_stall;

    always_comb
    begin
        pend_next = 2'(pend_reg + {1'b0, req_acc} - {1'b0, rsp_acc});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(present) &&
                                   $stable(member_count))
        else $error("result changed while stalled");

    a_present_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && present |-> status == ohs_pkg::STS_OK)
        else $error("present set on a failed request");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> member_count <= SLOTS)
        else $error("member count exceeds table size");

    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("result without an outstanding request");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two requests outstanding");

endmodule

bind open_addressing_hash_set ohs_checker #(.SLOTS(SLOTS)) u_ohs_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for open_addressing_hash_set against a running model of the key set.
`timescale 1ns / 1ps

module testbench;

    localparam int SLOTS       = ohs_pkg::DEF_SLOTS;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 64;
    localparam logic [ohs_pkg::FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
    localparam logic [ohs_pkg::FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;

    typedef struct {
        ohs_pkg::status_t              sts;
        logic                          present;
        logic [ohs_pkg::COUNT_W-1:0]   members;
    } set_answer_t;

    logic                                clk;
    logic                                rst_n        = 1'b0;
    logic                                req_valid    = 1'b0;
    logic                                req_stall;
    logic [ohs_pkg::FUNC_W-1:0]          func         = '0;
    logic [ohs_pkg::KEY_PORT_W-1:0]      key          = '0;
    logic [ohs_pkg::HASH_W-1:0]          key_hash     = '0;
    logic                                hashable     = 1'b0;
    logic                                rsp_valid;
    logic                                rsp_stall    = 1'b0;
    logic [ohs_pkg::STATUS_W-1:0]        status;
    logic                                present;
    logic [ohs_pkg::COUNT_W-1:0]         member_count;

    logic [ohs_pkg::KEY_PORT_W-1:0]      tbl_key  [SLOTS];
    logic [ohs_pkg::HASH_W-1:0]          tbl_hash [SLOTS];
    bit                                  tbl_live [SLOTS];
    bit                                  tbl_tomb [SLOTS];
    int unsigned                         n_live   = 0;
    int unsigned                         n_tomb   = 0;

    set_answer_t            answers_due [$];
    int                     mismatches = 0;
    int                     cycles     = 0;
    logic                   idle_on    = 1'b1;
    int                     hold_ask   = 0;
    int                     hold_seen  = 0;
    int                     hold_left  = 0;

    open_addressing_hash_set uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .key          (key),
        .key_hash     (key_hash),
        .hashable     (hashable),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .present      (present),
        .member_count (member_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit probe_slots(input logic [ohs_pkg::KEY_PORT_W-1:0] k,
                                       input logic [ohs_pkg::HASH_W-1:0] h,
                                       output int hit, output int ins, output bit ins_ok);
        int idx;
        int tomb_idx;
        bit have_tomb;
        hit       = 0;
        ins       = 0;
        ins_ok    = 1'b0;
        tomb_idx  = 0;
        have_tomb = 1'b0;
        idx       = int'(h & (SLOTS - 1));
        for (int n = 0; n < SLOTS; n++)
        begin
            if (tbl_live[idx])
            begin
                if (tbl_hash[idx] == h && tbl_key[idx] == k)
                begin
                    hit = idx;
                    return 1'b1;
                end
            end
            else if (tbl_tomb[idx])
            begin
                if (!have_tomb)
                begin
                    have_tomb = 1'b1;
                    tomb_idx  = idx;
                end
            end
            else
            begin
                ins    = have_tomb ? tomb_idx : idx;
                ins_ok = 1'b1;
                return 1'b0;
            end
            idx = (idx + 1) & (SLOTS - 1);
        end
        ins    = tomb_idx;
        ins_ok = have_tomb;
        return 1'b0;
    endfunction

    function automatic set_answer_t apply_set_op(input logic [ohs_pkg::FUNC_W-1:0] fn,
                                                 input logic [ohs_pkg::KEY_PORT_W-1:0] k,
                                                 input logic [ohs_pkg::HASH_W-1:0] h,
                                                 input logic hb);
        set_answer_t ans;
        bit found;
        bit ins_ok;
        int hit;
        int ins;
        ans.sts     = ohs_pkg::STS_OK;
        ans.present = 1'b0;
        found       = 1'b0;
        ins_ok      = 1'b0;
        hit         = 0;
        ins         = 0;
        if (fn == ohs_pkg::FN_CLEAR)
        begin
            foreach (tbl_live[i])
            begin
                tbl_live[i] = 1'b0;
                tbl_tomb[i] = 1'b0;
            end
            n_live = 0;
            n_tomb = 0;
        end
        else if (fn <= ohs_pkg::FN_DISCARD)
        begin
            if (!hb)
                ans.sts = ohs_pkg::STS_TYPE;
            else if (fn == ohs_pkg::FN_ADD)
            begin
                if ((n_live + n_tomb + 1) * 4 > SLOTS * 3)
                    ans.sts = ohs_pkg::STS_FULL;
                else
                begin
                    found = probe_slots(k, h, hit, ins, ins_ok);
                    if (found)
                    begin
                        tbl_key[hit]  = k;
                        tbl_hash[hit] = h;
                    end
                    else if (!ins_ok)
                        ans.sts = ohs_pkg::STS_FULL;
                    else
                    begin
                        if (tbl_tomb[ins])
                        begin
                            tbl_tomb[ins] = 1'b0;
                            n_tomb--;
                        end
                        tbl_key[ins]  = k;
                        tbl_hash[ins] = h;
                        tbl_live[ins] = 1'b1;
                        n_live++;
                    end
                end
            end
            else
            begin
                if (n_live != 0)
                    found = probe_slots(k, h, hit, ins, ins_ok);
                if (fn == ohs_pkg::FN_CONTAINS)
                    ans.present = found;
                else if (found)
                begin
                    tbl_live[hit] = 1'b0;
                    tbl_tomb[hit] = 1'b1;
                    n_live--;
                    n_tomb++;
                end
                else if (fn == ohs_pkg::FN_REMOVE)
                    ans.sts = ohs_pkg::STS_KEY;
            end
        end
        ans.members = n_live[ohs_pkg::COUNT_W-1:0];
        return ans;
    endfunction

    task automatic send_req(input logic [ohs_pkg::FUNC_W-1:0] fn,
                            input logic [ohs_pkg::KEY_PORT_W-1:0] k,
                            input logic [ohs_pkg::HASH_W-1:0] h, input logic hb);
        if (idle_on && $urandom_range(99) < 20)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= fn;
        key       <= k;
        key_hash  <= h;
        hashable  <= hb;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        answers_due.push_back(apply_set_op(fn, k, h, hb));
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [ohs_pkg::HASH_W-1:0] h_top;
        h_top = 32'hFFFF_FFFF;
        // empty set, then a collision chain that wraps from the top slot to slot 0
        send_req(ohs_pkg::FN_CONTAINS, 32'h0000_0000, h_top, 1'b1);
        send_req(ohs_pkg::FN_REMOVE,   32'h0000_0000, h_top, 1'b1);
        send_req(ohs_pkg::FN_DISCARD,  32'h0000_0000, h_top, 1'b1);
        send_req(ohs_pkg::FN_ADD,      32'h0000_0000, h_top, 1'b0);
        send_req(ohs_pkg::FN_ADD,      32'h0000_0000, h_top, 1'b1);
        send_req(ohs_pkg::FN_ADD,      32'h0000_0000, h_top, 1'b1);
        send_req(ohs_pkg::FN_ADD,      32'hFFFF_FFFF, h_top, 1'b1);
        send_req(ohs_pkg::FN_ADD,      32'h5A5A_A5A5, h_top, 1'b1);
        send_req(ohs_pkg::FN_CONTAINS, 32'hFFFF_FFFF, h_top, 1'b1);
        send_req(ohs_pkg::FN_CONTAINS, 32'hFFFF_FFFF, 32'h0000_03FF, 1'b1);
        // tombstone in the chain, probe past it, reuse it
        send_req(ohs_pkg::FN_REMOVE,   32'h0000_0000, h_top, 1'b1);
        send_req(ohs_pkg::FN_CONTAINS, 32'h5A5A_A5A5, h_top, 1'b1);
        send_req(ohs_pkg::FN_ADD,      32'h8000_0001, h_top, 1'b1);
        send_req(ohs_pkg::FN_DISCARD,  32'h8000_0001, h_top, 1'b1);
        send_req(ohs_pkg::FN_DISCARD,  32'h8000_0001, h_top, 1'b1);
        send_req(ohs_pkg::FN_REMOVE,   32'h8000_0001, h_top, 1'b1);
        send_req(ohs_pkg::FN_CONTAINS, 32'h5A5A_A5A5, h_top, 1'b0);
        send_req(ohs_pkg::FN_REMOVE,   32'h5A5A_A5A5, h_top, 1'b0);
        send_req(ohs_pkg::FN_DISCARD,  32'h5A5A_A5A5, h_top, 1'b0);
        for (int f = FN_SPARE_FIRST; f <= FN_SPARE_LAST; f++)
            send_req(3'(f), $urandom, $urandom, 1'($urandom));
        send_req(ohs_pkg::FN_CLEAR,    32'hFFFF_FFFF, h_top, 1'b0);
        send_req(ohs_pkg::FN_CONTAINS, 32'hFFFF_FFFF, h_top, 1'b1);
        send_req(ohs_pkg::FN_ADD,      32'h1234_5678, 32'h8000_0200, 1'b1);
    endtask

    task automatic test_mixed_ops();
        logic [ohs_pkg::KEY_PORT_W-1:0] pool_key  [64];
        logic [ohs_pkg::HASH_W-1:0]     pool_hash [64];
        logic [ohs_pkg::FUNC_W-1:0]     fn;
        logic [ohs_pkg::HASH_W-1:0]     h;
        int                             j;
        int                             r;
        // cluster the hashes around the wrap point so probes run long and collide
        for (int i = 0; i < 64; i++)
        begin
            pool_key[i] = $urandom;
            h           = $urandom;
            h[9:0]      = 10'd1016 + 10'($urandom_range(15));
            pool_hash[i] = (i % 4 == 3) ? pool_hash[i-1] : h;
        end
        idle_on <= 1'b0;
        for (int n = 0; n < 900; n++)
        begin
            if (n == 200)
                idle_on <= 1'b1;
            j = $urandom_range(63);
            h = ($urandom_range(9) == 0) ? ohs_pkg::HASH_W'($urandom) : pool_hash[j];
            r = $urandom_range(99);
            if (r < 35)
                fn = ohs_pkg::FN_ADD;
            else if (r < 60)
                fn = ohs_pkg::FN_CONTAINS;
            else if (r < 73)
                fn = ohs_pkg::FN_REMOVE;
            else if (r < 86)
                fn = ohs_pkg::FN_DISCARD;
            else if (r < 88)
                fn = ohs_pkg::FN_CLEAR;
            else if (r < 91)
                fn = 3'($urandom_range(FN_SPARE_LAST, FN_SPARE_FIRST));
            else
                fn = ohs_pkg::FN_ADD;
            send_req(fn, pool_key[j], h, 1'($urandom_range(19) != 0));
        end
    endtask

    task automatic test_fill_limit();
        logic [ohs_pkg::KEY_PORT_W-1:0] kept_key  [$];
        logic [ohs_pkg::HASH_W-1:0]     kept_hash [$];
        logic [ohs_pkg::KEY_PORT_W-1:0] k;
        logic [ohs_pkg::HASH_W-1:0]     h;
        int                             j;
        int                             r;
        send_req(ohs_pkg::FN_CLEAR, $urandom, $urandom, 1'b1);
        for (int n = 0; n < 790; n++)
        begin
            k = $urandom;
            h = $urandom;
            if (n == 400)
                hold_ask <= hold_ask + 1;
            send_req(ohs_pkg::FN_ADD, k, h, 1'b1);
            kept_key.push_back(k);
            kept_hash.push_back(h);
        end
        // at the load limit: adds fail even for present keys
        for (int n = 0; n < 60; n++)
        begin
            j = $urandom_range(kept_key.size() - 1);
            r = $urandom_range(4);
            if (r == 0)
                send_req(ohs_pkg::FN_CONTAINS, kept_key[j], kept_hash[j], 1'b1);
            else if (r == 1)
                send_req(ohs_pkg::FN_REMOVE, kept_key[j], kept_hash[j], 1'b1);
            else if (r == 2)
                send_req(ohs_pkg::FN_ADD, kept_key[j], kept_hash[j], 1'b1);
            else if (r == 3)
                send_req(ohs_pkg::FN_DISCARD, $urandom, $urandom, 1'b1);
            else
                send_req(ohs_pkg::FN_ADD, $urandom, $urandom, 1'b1);
        end
        send_req(ohs_pkg::FN_CLEAR, $urandom, $urandom, 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_ask)
        begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= idle_on && ($urandom_range(99) < 20);
    end

    always @(posedge clk)
    begin : check_answers
        set_answer_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (answers_due.size() == 0)
            begin
                $error("result with no request pending: status %0d, member_count %0d",
                       status, member_count);
                mismatches++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (status !== want.sts)
                begin
                    $error("status: expected %0d, got %0d", want.sts, status);
                    mismatches++;
                end
                if (present !== want.present)
                begin
                    $error("present: expected %0d, got %0d", want.present, present);
                    mismatches++;
                end
                if (member_count !== want.members)
                begin
                    $error("member_count: expected %0d, got %0d", want.members, member_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        drain();
        test_mixed_ops();
        test_fill_limit();
        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && answers_due.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: open_addressing_hash_set.f
design/ohs_pkg.sv
design/ohs_table.sv
design/open_addressing_hash_set.sv
design/ohs_checker.sv
tb/testbench.sv
